// ----- rtl/function_dataflow_tracker_unit_assert.svh -----
// assertion macros for the dataflow tracker
`ifndef FUNCTION_DATAFLOW_TRACKER_UNIT_ASSERT_SVH
`define FUNCTION_DATAFLOW_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define FDT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fdt check failed");

// next-cycle implication
`define FDT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fdt check failed");

`endif

// ----- rtl/fdt_pkg.sv -----
// types and constants shared by the dataflow tracker modules
`default_nettype none
package fdt_pkg;

    localparam logic [2:0] REQ_ENTER  = 3'd0;
    localparam logic [2:0] REQ_EXIT   = 3'd1;
    localparam logic [2:0] REQ_READ   = 3'd2;
    localparam logic [2:0] REQ_WRITE  = 3'd3;
    localparam logic [2:0] REQ_TICK   = 3'd4;
    localparam logic [2:0] REQ_RDPAIR = 3'd5;
    localparam logic [2:0] REQ_RDCNT  = 3'd6;

    localparam int          PADDR_W  = 3;
    localparam logic [2:0]  ADDR_EN  = 3'd0;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [4:0]  func_id;
        logic [63:0] mem_addr;
        logic [6:0]  access_size;
        logic [5:0]  entry_index;
    } t_in;

    typedef struct packed {
        logic        new_edge;
        logic [4:0]  caller_id;
        logic [4:0]  callee_id;
        logic        pair_valid;
        logic [4:0]  producer_id;
        logic [4:0]  consumer_id;
        logic [31:0] pair_bytes;
        logic [31:0] instr_total;
        logic        overflow;
    } t_out;

    typedef enum logic [2:0] {
        OP_NOP, OP_ENTER, OP_EXIT, OP_READ, OP_WRITE, OP_TICK, OP_RDPAIR, OP_RDCNT
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [4:0]  fn;
        logic [63:0] addr;
        logic [6:0]  size;
        logic [5:0]  idx;
    } t_qitem;

    typedef enum logic [2:0] {
        S_IDLE, S_TOP, S_EDGE, S_SHADOW, S_PAIR, S_RDP, S_OUT
    } t_bstate;

    typedef struct packed {
        logic [63:0] addr;
        logic [4:0]  writer;
        logic [4:0]  reader;
    } t_shadow;

    typedef struct packed {
        logic [4:0]  prod;
        logic [4:0]  cons;
        logic [31:0] total;
    } t_pair;

    typedef struct packed {
        logic [4:0] caller;
        logic [4:0] callee;
    } t_edge;

endpackage
`default_nettype wire

// ----- rtl/fdt_front.sv -----
// front end: request classification and two-entry queue
`default_nettype none
module fdt_front import fdt_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire logic   i_valid,
    output logic        o_stall,
    input  wire t_in    i_in,
    output logic        o_q_vld,
    output t_qitem      o_q,
    input  wire logic   i_q_pop
);

    t_qitem     r_qm [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_qitem     cls;
    logic       push;

    always_comb begin
        cls.fn   = i_in.func_id;
        cls.addr = i_in.mem_addr;
        cls.size = i_in.access_size;
        cls.idx  = i_in.entry_index;
        case (i_in.req_type)
            REQ_ENTER:  cls.op = i_en ? OP_ENTER : OP_NOP;
            REQ_EXIT:   cls.op = i_en ? OP_EXIT  : OP_NOP;
            REQ_READ:   cls.op = i_en ? OP_READ  : OP_NOP;
            REQ_WRITE:  cls.op = i_en ? OP_WRITE : OP_NOP;
            REQ_TICK:   cls.op = i_en ? OP_TICK  : OP_NOP;
            REQ_RDPAIR: cls.op = OP_RDPAIR;
            REQ_RDCNT:  cls.op = OP_RDCNT;
            default:    cls.op = OP_NOP;
        endcase
    end

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall;
    assign o_q_vld = (r_cnt != 2'd0);
    assign o_q     = r_qm[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_qm[r_wp] <= cls;
    end

endmodule
`default_nettype wire

// ----- rtl/fdt_back.sv -----
// back end: table scans, updates and result register
`default_nettype none
`include "function_dataflow_tracker_unit_assert.svh"
module fdt_back import fdt_pkg::*; #(
    parameter int SHADOW_ENTRIES = 1024,
    parameter int STACK_SLOTS    = 64,
    parameter int EDGE_SLOTS     = 64,
    parameter int PAIR_SLOTS     = 64,
    parameter int FUNC_SLOTS     = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_vld,
    input  wire t_qitem i_q,
    output logic        o_q_pop,
    output logic        o_valid,
    input  wire logic   i_stall,
    output t_out        o_out
);

    localparam int SHW = $clog2(SHADOW_ENTRIES);
    localparam int STW = $clog2(STACK_SLOTS);
    localparam int EDW = $clog2(EDGE_SLOTS);
    localparam int PRW = $clog2(PAIR_SLOTS);
    localparam int FW  = $clog2(FUNC_SLOTS);
    localparam int M1  = (SHW > STW) ? SHW : STW;
    localparam int M2  = (EDW > PRW) ? EDW : PRW;
    localparam int SCW = ((M1 > M2) ? M1 : M2) + 1;

    t_shadow r_sh_mem [SHADOW_ENTRIES];
    t_pair   r_pr_mem [PAIR_SLOTS];
    t_edge   r_ed_mem [EDGE_SLOTS];
    logic [4:0] r_st_mem [STACK_SLOTS];
    t_shadow r_sh_q;
    t_pair   r_pr_q;
    t_edge   r_ed_q;
    logic [4:0] r_st_q;

    t_bstate r_state, n_state;
    t_qitem  r_it, n_it;
    t_out    r_res, n_res, r_out, n_out;
    logic    r_o_vld, n_o_vld;
    logic [4:0] r_cur, n_cur, r_caller, n_caller, r_prod, n_prod;
    logic [STW:0] r_depth, n_depth;
    logic [SHW:0] r_sh_used, n_sh_used;
    logic [EDW:0] r_ed_used, n_ed_used;
    logic [PRW:0] r_pr_used, n_pr_used;
    logic [SCW-1:0] r_scan, n_scan, r_rd_idx, n_rd_idx, ra;
    logic    r_rd_vld, n_rd_vld;
    logic    r_exited [FUNC_SLOTS];
    logic [31:0] r_icnt [FUNC_SLOTS];

    logic    sh_we, pr_we, ed_we, st_we;
    logic [SHW-1:0] sh_wa;
    logic [PRW-1:0] pr_wa;
    logic [EDW-1:0] ed_wa;
    logic [STW-1:0] st_wa;
    t_shadow sh_wd;
    t_pair   pr_wd;
    t_edge   ed_wd;
    logic    ex_set, cnt_inc, issue, cur_ok;
    logic [FW-1:0] cur_idx;
    logic [32:0] sum;
    logic [31:0] tot;

    assign cur_idx = FW'(r_cur);
    assign cur_ok  = (32'(r_cur) < FUNC_SLOTS);
    assign sum     = {1'b0, r_pr_q.total} + 33'(r_it.size);
    assign tot     = sum[32] ? '1 : sum[31:0];

    always_comb begin
        n_state = r_state; n_it = r_it; n_res = r_res; n_out = r_out;
        n_o_vld = r_o_vld && i_stall;
        n_cur = r_cur; n_caller = r_caller; n_prod = r_prod; n_depth = r_depth;
        n_sh_used = r_sh_used; n_ed_used = r_ed_used; n_pr_used = r_pr_used;
        n_scan = r_scan; n_rd_idx = r_rd_idx; n_rd_vld = 1'b0;
        o_q_pop = 1'b0; ra = r_scan; issue = 1'b0;
        sh_we = 1'b0; sh_wa = r_rd_idx[SHW-1:0]; sh_wd = {r_it.addr, r_cur, 5'd0};
        pr_we = 1'b0; pr_wa = r_rd_idx[PRW-1:0]; pr_wd = {r_prod, r_cur, tot};
        ed_we = 1'b0; ed_wa = r_ed_used[EDW-1:0]; ed_wd = {r_caller, r_it.fn};
        st_we = 1'b0; st_wa = r_depth[STW-1:0];
        ex_set = 1'b0; cnt_inc = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_vld) begin
                    o_q_pop = 1'b1;
                    n_it = i_q;
                    n_res = '0;
                    n_scan = '0;
                    n_state = S_OUT;
                    case (i_q.op)
                        OP_ENTER: begin
                            ra = SCW'(r_depth) - SCW'(1);
                            n_state = S_TOP;
                        end
                        OP_EXIT: begin
                            if (r_depth != '0) n_depth = r_depth - 1'b1;
                            ex_set = cur_ok;
                        end
                        OP_READ, OP_WRITE: n_state = S_SHADOW;
                        OP_TICK: cnt_inc = cur_ok && !r_exited[cur_idx];
                        OP_RDPAIR: begin
                            ra = SCW'(i_q.idx);
                            if (32'(i_q.idx) < 32'(r_pr_used)) n_state = S_RDP;
                        end
                        OP_RDCNT: begin
                            if (32'(i_q.fn) < FUNC_SLOTS)
                                n_res.instr_total = r_icnt[FW'(i_q.fn)];
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_TOP: begin
                if (r_depth < (STW+1)'(STACK_SLOTS)) begin
                    st_we = 1'b1;
                    n_depth = r_depth + 1'b1;
                end else begin
                    n_res.overflow = 1'b1;
                end
                n_cur = r_it.fn;
                if (r_cur != 5'd0) begin
                    n_caller = (r_depth != '0) ? r_st_q : 5'd0;
                    n_state = S_EDGE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_EDGE: begin
                issue = r_scan < SCW'(r_ed_used);
                if (r_rd_vld && r_ed_q == {r_caller, r_it.fn}) begin
                    n_state = S_OUT;
                end else if (!r_rd_vld && !issue) begin
                    n_res.caller_id = r_caller;
                    n_res.callee_id = r_it.fn;
                    if (r_ed_used < (EDW+1)'(EDGE_SLOTS)) begin
                        ed_we = 1'b1;
                        n_ed_used = r_ed_used + 1'b1;
                        n_res.new_edge = 1'b1;
                    end else begin
                        n_res.overflow = 1'b1;
                    end
                    n_state = S_OUT;
                end else if (issue) begin
                    n_scan = r_scan + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_scan;
                end
            end
            S_SHADOW: begin
                issue = r_scan < SCW'(r_sh_used);
                if (r_rd_vld && r_sh_q.addr == r_it.addr) begin
                    n_state = S_OUT;
                    if (r_it.op == OP_WRITE) begin
                        sh_we = 1'b1;
                    end else if (r_sh_q.reader != r_cur) begin
                        sh_we = 1'b1;
                        sh_wd = {r_it.addr, r_sh_q.writer, r_cur};
                        n_prod = r_sh_q.writer;
                        n_res.producer_id = r_sh_q.writer;
                        n_res.consumer_id = r_cur;
                        n_scan = '0;
                        n_state = S_PAIR;
                    end
                end else if (!r_rd_vld && !issue) begin
                    if (r_it.op == OP_WRITE) begin
                        if (r_sh_used < (SHW+1)'(SHADOW_ENTRIES)) begin
                            sh_we = 1'b1;
                            sh_wa = r_sh_used[SHW-1:0];
                            n_sh_used = r_sh_used + 1'b1;
                        end else begin
                            n_res.overflow = 1'b1;
                        end
                    end
                    n_state = S_OUT;
                end else if (issue) begin
                    n_scan = r_scan + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_scan;
                end
            end
            S_PAIR: begin
                issue = r_scan < SCW'(r_pr_used);
                if (r_rd_vld && r_pr_q.prod == r_prod && r_pr_q.cons == r_cur) begin
                    pr_we = 1'b1;
                    n_res.pair_valid = 1'b1;
                    n_res.pair_bytes = tot;
                    n_state = S_OUT;
                end else if (!r_rd_vld && !issue) begin
                    if (r_pr_used < (PRW+1)'(PAIR_SLOTS)) begin
                        pr_we = 1'b1;
                        pr_wa = r_pr_used[PRW-1:0];
                        pr_wd = {r_prod, r_cur, 32'(r_it.size)};
                        n_pr_used = r_pr_used + 1'b1;
                        n_res.pair_valid = 1'b1;
                        n_res.pair_bytes = 32'(r_it.size);
                    end else begin
                        n_res.overflow = 1'b1;
                    end
                    n_state = S_OUT;
                end else if (issue) begin
                    n_scan = r_scan + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_scan;
                end
            end
            S_RDP: begin
                n_res.pair_valid = 1'b1;
                n_res.producer_id = r_pr_q.prod;
                n_res.consumer_id = r_pr_q.cons;
                n_res.pair_bytes = r_pr_q.total;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_o_vld || !i_stall) begin
                    n_o_vld = 1'b1;
                    n_out = r_res;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_o_vld <= 1'b0;
            r_cur <= '0;
            r_depth <= '0;
            r_sh_used <= '0;
            r_ed_used <= '0;
            r_pr_used <= '0;
            r_rd_vld <= 1'b0;
            for (int i = 0; i < FUNC_SLOTS; i++) begin
                r_exited[i] <= 1'b0;
                r_icnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_o_vld <= n_o_vld;
            r_cur <= n_cur;
            r_depth <= n_depth;
            r_sh_used <= n_sh_used;
            r_ed_used <= n_ed_used;
            r_pr_used <= n_pr_used;
            r_rd_vld <= n_rd_vld;
            if (ex_set) r_exited[cur_idx] <= 1'b1;
            if (cnt_inc && r_icnt[cur_idx] != '1) r_icnt[cur_idx] <= r_icnt[cur_idx] + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_it <= n_it;
        r_res <= n_res;
        r_out <= n_out;
        r_caller <= n_caller;
        r_prod <= n_prod;
        r_scan <= n_scan;
        r_rd_idx <= n_rd_idx;
    end

    always_ff @(posedge i_clk) begin
        if (sh_we) r_sh_mem[sh_wa] <= sh_wd;
        r_sh_q <= r_sh_mem[ra[SHW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (pr_we) r_pr_mem[pr_wa] <= pr_wd;
        r_pr_q <= r_pr_mem[ra[PRW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (ed_we) r_ed_mem[ed_wa] <= ed_wd;
        r_ed_q <= r_ed_mem[ra[EDW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (st_we) r_st_mem[st_wa] <= r_it.fn;
        r_st_q <= r_st_mem[ra[STW-1:0]];
    end

    assign o_valid = r_o_vld;
    assign o_out   = r_out;

    `FDT_ASSERT_NOW(a_pop_idle, o_q_pop, r_state == S_IDLE)
    `FDT_ASSERT_NOW(a_depth_max, 1'b1, r_depth <= (STW+1)'(STACK_SLOTS))
    `FDT_ASSERT_NOW(a_pair_max, 1'b1, r_pr_used <= (PRW+1)'(PAIR_SLOTS))
    `FDT_ASSERT_NEXT(a_out_load, r_state == S_OUT && !(r_o_vld && i_stall), o_valid && r_state == S_IDLE)

endmodule
`default_nettype wire

// ----- rtl/function_dataflow_tracker_unit.sv -----
// Function dataflow tracker. Requests enter a registered two-entry queue ahead of the back
// end, which runs one request at a time. Exit, tick, count readout and disabled requests
// go from idle straight to the result state; a pair readout with a valid index first reads
// the pair table, and an enter first reads the call stack top. An enter with a current
// function then scans the recorded edges, a read or write scans the shadow entries in use,
// and a read that credits a pair then scans the pair entries in use. These scans go one
// entry per cycle through a single read port of each table memory. A stalled result holds
// the back end until it is taken. No clearing pass is needed after reset.
`default_nettype none
module function_dataflow_tracker_unit import fdt_pkg::*; #(
    parameter int SHADOW_ENTRIES = 1024,
    parameter int STACK_SLOTS    = 64,
    parameter int EDGE_SLOTS     = 64,
    parameter int PAIR_SLOTS     = 64,
    parameter int FUNC_SLOTS     = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in                i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out                    o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic   r_en;
    logic   q_vld, q_pop;
    t_qitem q_item;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_EN) ? {31'd0, r_en} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
        end else if (psel && penable && pwrite && paddr == ADDR_EN) begin
            r_en <= pwdata[0];
        end
    end

    fdt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_en),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_in    (i_in),
        .o_q_vld (q_vld),
        .o_q     (q_item),
        .i_q_pop (q_pop)
    );

    fdt_back #(
        .SHADOW_ENTRIES (SHADOW_ENTRIES),
        .STACK_SLOTS    (STACK_SLOTS),
        .EDGE_SLOTS     (EDGE_SLOTS),
        .PAIR_SLOTS     (PAIR_SLOTS),
        .FUNC_SLOTS     (FUNC_SLOTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_vld (q_vld),
        .i_q     (q_item),
        .o_q_pop (q_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire
